/* rtl/jtms_pkg.sv */
package jtms_pkg;

	// tap controller states in standard order
	localparam logic [3:0] TAP_TLR     = 4'd0;
	localparam logic [3:0] TAP_RTI     = 4'd1;
	localparam logic [3:0] TAP_SEL_DR  = 4'd2;
	localparam logic [3:0] TAP_CAP_DR  = 4'd3;
	localparam logic [3:0] TAP_SH_DR   = 4'd4;
	localparam logic [3:0] TAP_EX1_DR  = 4'd5;
	localparam logic [3:0] TAP_PAU_DR  = 4'd6;
	localparam logic [3:0] TAP_EX2_DR  = 4'd7;
	localparam logic [3:0] TAP_UPD_DR  = 4'd8;
	localparam logic [3:0] TAP_SEL_IR  = 4'd9;
	localparam logic [3:0] TAP_CAP_IR  = 4'd10;
	localparam logic [3:0] TAP_SH_IR   = 4'd11;
	localparam logic [3:0] TAP_EX1_IR  = 4'd12;
	localparam logic [3:0] TAP_PAU_IR  = 4'd13;
	localparam logic [3:0] TAP_EX2_IR  = 4'd14;
	localparam logic [3:0] TAP_UPD_IR  = 4'd15;

	// command codes
	localparam logic [2:0] FUNC_RESET  = 3'd0;
	localparam logic [2:0] FUNC_GOTO   = 3'd1;
	localparam logic [2:0] FUNC_SH_IR  = 3'd2;
	localparam logic [2:0] FUNC_SH_DR  = 3'd3;
	localparam logic [2:0] FUNC_TOGGLE = 3'd4;

	localparam int CNT_W        = 4;
	localparam int EMIT_W       = 5;
	localparam int MAX_RESULTS  = 16;
	localparam int RESET_CLOCKS = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOCK,
		ST_WALK_PRE,
		ST_SHIFT,
		ST_WALK_POST
	} seq_state_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [CNT_W-1:0] count;
	} shreg_ctl_t;

	// standard tap transition
	function automatic logic [3:0] tap_next(logic [3:0] s, logic tms);
		logic [3:0] r;
		unique case (s)
			TAP_TLR:    r = tms ? TAP_TLR    : TAP_RTI;
			TAP_RTI:    r = tms ? TAP_SEL_DR : TAP_RTI;
			TAP_SEL_DR: r = tms ? TAP_SEL_IR : TAP_CAP_DR;
			TAP_CAP_DR: r = tms ? TAP_EX1_DR : TAP_SH_DR;
			TAP_SH_DR:  r = tms ? TAP_EX1_DR : TAP_SH_DR;
			TAP_EX1_DR: r = tms ? TAP_UPD_DR : TAP_PAU_DR;
			TAP_PAU_DR: r = tms ? TAP_EX2_DR : TAP_PAU_DR;
			TAP_EX2_DR: r = tms ? TAP_UPD_DR : TAP_SH_DR;
			TAP_UPD_DR: r = tms ? TAP_SEL_DR : TAP_RTI;
			TAP_SEL_IR: r = tms ? TAP_TLR    : TAP_CAP_IR;
			TAP_CAP_IR: r = tms ? TAP_EX1_IR : TAP_SH_IR;
			TAP_SH_IR:  r = tms ? TAP_EX1_IR : TAP_SH_IR;
			TAP_EX1_IR: r = tms ? TAP_UPD_IR : TAP_PAU_IR;
			TAP_PAU_IR: r = tms ? TAP_EX2_IR : TAP_PAU_IR;
			TAP_EX2_IR: r = tms ? TAP_UPD_IR : TAP_SH_IR;
			TAP_UPD_IR: r = tms ? TAP_SEL_DR : TAP_RTI;
			default:    r = TAP_TLR;
		endcase
		return r;
	endfunction

	// tms for one step of the shortest walk from s toward t
	function automatic logic walk_tms(logic [3:0] s, logic [3:0] t);
		logic       t_dr;
		logic       t_ir;
		logic       same;
		logic [3:0] base;
		logic [3:0] off;
		logic [3:0] toff;
		logic       r;
		t_dr = (t >= TAP_CAP_DR) && (t <= TAP_UPD_DR);
		t_ir = (t >= TAP_CAP_IR);
		base = (s <= TAP_UPD_DR) ? TAP_CAP_DR : TAP_CAP_IR;
		off  = s - base;
		same = (base == TAP_CAP_DR) ? t_dr : t_ir;
		// other column: an offset that matches none of the tests below
		toff = same ? (t - base) : 4'd15;
		if (s == TAP_TLR) begin
			r = 1'b0;
		end else if (s == TAP_RTI) begin
			r = 1'b1;
		end else if (s == TAP_SEL_DR) begin
			r = !t_dr;
		end else if (s == TAP_SEL_IR) begin
			r = !t_ir;
		end else begin
			unique case (off)
				4'd0:    r = (toff != 4'd1);
				4'd1:    r = 1'b1;
				4'd2:    r = !((toff >= 4'd1) && (toff <= 4'd4));
				4'd3:    r = 1'b1;
				4'd4:    r = !((toff >= 4'd1) && (toff <= 4'd3));
				default: r = (t != TAP_RTI);
			endcase
		end
		return r;
	endfunction

endpackage

/* rtl/jtms_shreg.sv */
module jtms_shreg (
	input  logic               clk,
	input  logic               arst_n,
	input  jtms_pkg::shreg_ctl_t ctl,
	input  logic [7:0]         load_data,
	output logic               bit_out,
	output logic               last_bit
);
	import jtms_pkg::*;

	logic [7:0]       data_q;
	logic [CNT_W-1:0] count_q;

	// data goes out lsb first, zeros fill from the top
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_data;
		end else if (ctl.step) begin
			data_q <= {1'b0, data_q[7:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.load) begin
			count_q <= ctl.count;
		end else if (ctl.step && count_q != '0) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign bit_out  = data_q[0];
	assign last_bit = (count_q == CNT_W'(1));

endmodule

/* rtl/jtms_tap.sv */
module jtms_tap (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       tms_in,
	input  logic [3:0] goal,
	output logic [3:0] state,
	output logic       walk_bit
);
	import jtms_pkg::*;

	logic [3:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TAP_TLR;
		end else if (step) begin
			state_q <= tap_next(state_q, tms_in);
		end
	end

	assign state    = state_q;
	assign walk_bit = walk_tms(state_q, goal);

endmodule

/* rtl/jtag_tap_master_sequencer_core.sv */
// jtag tap master sequencer
// input channel (in_valid/in_ready) takes one command: func, target_state,
// tdi_bits, bit_count, final_chunk. output channel (out_valid/out_ready)
// gives one transfer per tck cycle with tms, tdi and last, last marking the
// final cycle of the command. a command yields at most 16 transfers; tck cycles
// beyond that are dropped and the tracked tap state follows only the ones sent.
// the first result is registered after the command transfer; a shift that
// already sits in its shift state first confirms that state with no result.
// every shift confirms its shift state before the data, and a walk to the
// current state or an unknown func yields no result. the rate is one tck cycle per
// clock while the receiver takes each result, but for the step that confirms the
// shift state; it is set by the bit-serial data shifter and the one-step tap walk
// logic. in_ready is high only while the sequencer is idle; a pending last result
// may still wait in the output register while the next command is taken.
// a stalled receiver holds the output register and keeps the sequencer from producing new results.
// reset puts the tracked tap state in test-logic-reset and empties the
// output register. commands that yield nothing (unknown func, or a walk to
// the current state) are taken and leave the state unchanged.
module jtag_tap_master_sequencer_core #(
	parameter int CHUNK_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] func,
	input  logic [3:0] target_state,
	input  logic [7:0] tdi_bits,
	input  logic [3:0] bit_count,
	input  logic       final_chunk,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tms,
	output logic       tdi,
	output logic       last
);
	import jtms_pkg::*;

	// largest count the 4-bit field can ask for after clamping
	localparam logic [CNT_W-1:0] CLAMP_HI = CNT_W'((CHUNK_BITS > 15) ? 15 : CHUNK_BITS);

	seq_state_t        state_q, state_d;
	logic [3:0]        goal_q;      // end state of the command
	logic [3:0]        shift_st_q;  // shift state of the scanned register
	logic              leave_q;     // final chunk leaves the shift state
	logic [EMIT_W-1:0] emit_cnt_q;

	logic              out_valid_q;
	logic              tms_q;
	logic              tdi_q;
	logic              last_q;

	logic              in_fire;
	logic              can_emit;
	logic              emit;
	logic              emit_tms;
	logic              emit_tdi;
	logic              emit_end;
	logic              res_last;
	logic [CNT_W-1:0]  n_clamped;

	shreg_ctl_t        sh_ctl;
	logic              sh_bit;
	logic              sh_last;

	logic [3:0]        tap_st;
	logic [3:0]        walk_goal;
	logic              walk_bit;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign can_emit = !out_valid_q || out_ready;

	// bit count clamped to 1..chunk size, at most 15
	always_comb begin
		n_clamped = (bit_count > CLAMP_HI) ? CLAMP_HI : bit_count;
		if (n_clamped == '0) begin
			n_clamped = CNT_W'(1);
		end
	end

	// the walk logic aims at the shift state before data, else at the end state
	assign walk_goal = (state_q == ST_WALK_PRE) ? shift_st_q : goal_q;

	// sequencer: next state and the tck cycle to produce
	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		emit_tms   = 1'b0;
		emit_tdi   = 1'b0;
		emit_end   = 1'b0;
		sh_ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func)
						FUNC_RESET: begin
							sh_ctl.load  = 1'b1;
							sh_ctl.count = CNT_W'(RESET_CLOCKS);
							state_d      = ST_CLOCK;
						end
						FUNC_TOGGLE: begin
							sh_ctl.load  = 1'b1;
							sh_ctl.count = n_clamped;
							state_d      = ST_CLOCK;
						end
						FUNC_GOTO: begin
							state_d = ST_WALK_POST;
						end
						FUNC_SH_IR, FUNC_SH_DR: begin
							sh_ctl.load  = 1'b1;
							sh_ctl.count = n_clamped;
							state_d      = ST_WALK_PRE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CLOCK: begin
				emit     = can_emit;
				emit_tms = 1'b1;
				emit_end = sh_last;
			end
			ST_WALK_PRE: begin
				if (tap_st == shift_st_q) begin
					state_d = ST_SHIFT;
				end else begin
					emit     = can_emit;
					emit_tms = walk_bit;
				end
			end
			ST_SHIFT: begin
				emit     = can_emit;
				emit_tms = leave_q && sh_last;
				emit_tdi = sh_bit;
				// an end state of exit1 needs no walk after the data
				emit_end = sh_last && (!leave_q || tap_next(tap_st, 1'b1) == goal_q);
				sh_ctl.step = can_emit;
				if (can_emit && sh_last) begin
					state_d = ST_WALK_POST;
				end
			end
			ST_WALK_POST: begin
				if (tap_st == goal_q) begin
					state_d = ST_IDLE;
				end else begin
					emit     = can_emit;
					emit_tms = walk_bit;
					emit_end = (tap_next(tap_st, walk_bit) == goal_q);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (state_q == ST_CLOCK) begin
			sh_ctl.step = can_emit;
		end
		// the last cycle of a command, natural or cut at the result limit
		res_last = emit_end || (emit_cnt_q == EMIT_W'(MAX_RESULTS - 1));
		if (emit && res_last) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command fields captured at the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q     <= TAP_TLR;
			shift_st_q <= TAP_SH_DR;
			leave_q    <= 1'b0;
			emit_cnt_q <= '0;
		end else if (in_fire) begin
			goal_q     <= target_state;
			shift_st_q <= (func == FUNC_SH_IR) ? TAP_SH_IR : TAP_SH_DR;
			leave_q    <= final_chunk &&
				(target_state != ((func == FUNC_SH_IR) ? TAP_SH_IR : TAP_SH_DR));
			emit_cnt_q <= '0;
		end else if (emit) begin
			emit_cnt_q <= emit_cnt_q + EMIT_W'(1);
		end
	end

	// output register, parts the sequencer from the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tms_q  <= emit_tms;
			tdi_q  <= emit_tdi;
			last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign tms       = tms_q;
	assign tdi       = tdi_q;
	assign last      = last_q;

	jtms_shreg u_shreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sh_ctl),
		.load_data (tdi_bits),
		.bit_out   (sh_bit),
		.last_bit  (sh_last)
	);

	jtms_tap u_tap (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (emit),
		.tms_in   (emit_tms),
		.goal     (walk_goal),
		.state    (tap_st),
		.walk_bit (walk_bit)
	);

	// a cycle marked last ends the command
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res_last |=> state_q == ST_IDLE)
		else $error("sequencer busy after last cycle");

	// never more cycles than the result limit
	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= EMIT_W'(MAX_RESULTS))
		else $error("result limit exceeded");

	// a reset command starts with tms-high clocks
	a_reset_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && func == FUNC_RESET |=> state_q == ST_CLOCK && emit_cnt_q == '0)
		else $error("reset command not started");

	// data bits keep coming until the shifter runs out
	a_shift_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT && emit && !sh_last && !res_last |=> state_q == ST_SHIFT)
		else $error("shift left early");

	// a new output transfer is only produced while a command is running
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> state_q != ST_IDLE && can_emit)
		else $error("cycle produced while idle or stalled");

endmodule
